// ----- rtl/dtfp_pkg.sv -----
// Shared types, character codes and the power-of-ten table for the decimal text parser.
package dtfp_pkg;

  // Default width of the value arithmetic; results wrap at this many bits.
  localparam int unsigned ValueBitsDefault = 64;

  // Largest number of fraction digits kept; larger settings act as this one.
  localparam logic [4:0] MaxScale = 5'd18;

  // Character codes recognised by the parser.
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  // Parse phase of the field under way.
  typedef enum logic [3:0] {
    PhStart = 4'b0001,
    PhWhole = 4'b0010,
    PhFrac  = 4'b0100,
    PhStop  = 4'b1000
  } dtfp_phase_e;

  // Operands of the final scaling, handed from the parser to the result pipeline.
  typedef struct packed {
    logic [63:0] whole;
    logic [59:0] frac;
    logic [59:0] pow_scale;
    logic [59:0] pow_pad;
    logic        neg;
  } dtfp_operands_t;

  // Ten to the power of the argument, for arguments up to MaxScale.
  function automatic logic [59:0] pow_ten(input logic [4:0] exp_val);
    logic [59:0] res;
    case (exp_val)
      5'd0:    res = 60'd1;
      5'd1:    res = 60'd10;
      5'd2:    res = 60'd100;
      5'd3:    res = 60'd1000;
      5'd4:    res = 60'd10000;
      5'd5:    res = 60'd100000;
      5'd6:    res = 60'd1000000;
      5'd7:    res = 60'd10000000;
      5'd8:    res = 60'd100000000;
      5'd9:    res = 60'd1000000000;
      5'd10:   res = 60'd10000000000;
      5'd11:   res = 60'd100000000000;
      5'd12:   res = 60'd1000000000000;
      5'd13:   res = 60'd10000000000000;
      5'd14:   res = 60'd100000000000000;
      5'd15:   res = 60'd1000000000000000;
      5'd16:   res = 60'd10000000000000000;
      5'd17:   res = 60'd100000000000000000;
      5'd18:   res = 60'd1000000000000000000;
      default: res = 60'd1;
    endcase
    return res;
  endfunction

endpackage

// ----- rtl/dtfp_result.sv -----
// Result pipeline: scales the whole and fraction parts, sums, negates and wraps.
module dtfp_result #(
  parameter int unsigned VALUE_BITS = dtfp_pkg::ValueBitsDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    op_valid_i,
  input  dtfp_pkg::dtfp_operands_t op_i,
  output logic                    op_ready_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [63:0]      scaled_value_o
);
  import dtfp_pkg::*;

  // Stage valid flags and the space each stage has to advance.
  logic prod_v_q, sum_v_q, out_v_q;
  logic can_prod, can_sum, can_out;

  assign can_out    = !out_v_q || !out_stall_i;
  assign can_sum    = !sum_v_q || can_out;
  assign can_prod   = !prod_v_q || can_sum;
  assign op_ready_o = can_prod;

  // Operand halves for the 32 by 32 partial products.
  logic [31:0] wl, wh, pl, ph, fl, fh, ql, qh;
  logic [63:0] ll_whole_c, ll_frac_c;
  logic [31:0] cross_c;

  assign wl = op_i.whole[31:0];
  assign wh = op_i.whole[63:32];
  assign pl = op_i.pow_scale[31:0];
  assign ph = 32'(op_i.pow_scale[59:32]);
  assign fl = op_i.frac[31:0];
  assign fh = 32'(op_i.frac[59:32]);
  assign ql = op_i.pow_pad[31:0];
  assign qh = 32'(op_i.pow_pad[59:32]);

  // Low halves multiply in full; cross terms only matter in their low 32 bits.
  assign ll_whole_c = 64'(wl) * 64'(pl);
  assign ll_frac_c  = 64'(fl) * 64'(ql);
  assign cross_c    = (wh * pl) + (wl * ph) + (fh * ql) + (fl * qh);

  logic [63:0] ll_whole_q, ll_frac_q;
  logic [31:0] cross_q;
  logic        prod_neg_q;

  // Product stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
    end else if (can_prod) begin
      prod_v_q <= op_valid_i;
    end
  end

  // Product stage payload.
  always_ff @(posedge clk_i) begin
    if (can_prod && op_valid_i) begin
      ll_whole_q <= ll_whole_c;
      ll_frac_q  <= ll_frac_c;
      cross_q    <= cross_c;
      prod_neg_q <= op_i.neg;
    end
  end

  logic [63:0] sum_q;
  logic        sum_neg_q;

  // Sum stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_v_q <= 1'b0;
    end else if (can_sum) begin
      sum_v_q <= prod_v_q;
    end
  end

  // Sum stage payload: partial products folded into the wrapped total.
  always_ff @(posedge clk_i) begin
    if (can_sum && prod_v_q) begin
      sum_q     <= ll_whole_q + ll_frac_q + {cross_q, 32'd0};
      sum_neg_q <= prod_neg_q;
    end
  end

  logic signed [VALUE_BITS-1:0] out_q;
  logic        [63:0]           signed_sum;

  assign signed_sum = sum_neg_q ? (64'd0 - sum_q) : sum_q;

  // Output register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (can_out) begin
      out_v_q <= sum_v_q;
    end
  end

  // Output register payload, wrapped to the value width.
  always_ff @(posedge clk_i) begin
    if (can_out && sum_v_q) begin
      out_q <= VALUE_BITS'(signed_sum);
    end
  end

  assign out_valid_o    = out_v_q;
  assign scaled_value_o = 64'(out_q);

endmodule

// ----- rtl/decimal_text_to_fixed_point.sv -----
// Top level: decimal text field parser giving a value scaled by ten to the set scale.
// Takes one character beat per cycle, back to back while in_stall_o is low, in any field pattern.
// The beat that ends a field loads the operand register; the result then passes through
// the partial-product stage, the sum stage and the output register in that order, and up
// to four results can be in flight.
// Reset is asynchronous and active low; it clears the scale to zero and the field state.
module decimal_text_to_fixed_point #(
  parameter int unsigned VALUE_BITS = dtfp_pkg::ValueBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [4:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         text_char_i,
  input  logic               field_end_i,
  input  logic               no_char_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [63:0] scaled_value_o
);
  import dtfp_pkg::*;

  // Scale register and its clamped value.
  logic [4:0] scale_q;
  logic [4:0] scale_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= 5'd0;
    end else if (cfg_we_i) begin
      scale_q <= cfg_wdata_i;
    end
  end

  assign scale_eff = (scale_q > MaxScale) ? MaxScale : scale_q;

  // Handshake between the operand register and the result pipeline.
  logic op_v_q, res_ready, can_op, accept;

  assign can_op     = !op_v_q || res_ready;
  assign in_stall_o = !can_op;
  assign accept     = in_valid_i && can_op;

  // Field state.
  dtfp_phase_e            phase_q, phase_d, upd_phase;
  logic                   neg_q, neg_d, upd_neg;
  logic [VALUE_BITS-1:0]  whole_q, whole_d, upd_whole, whole_x10;
  logic [59:0]            frac_q, frac_d, upd_frac, frac_x10;
  logic [4:0]             digits_q, digits_d, upd_digits;

  logic       is_digit;
  logic [3:0] digit;

  assign is_digit  = (text_char_i >= CharZero) && (text_char_i <= CharNine);
  assign digit     = text_char_i[3:0];
  assign whole_x10 = (whole_q << 3) + (whole_q << 1) + VALUE_BITS'(digit);
  assign frac_x10  = (frac_q << 3) + (frac_q << 1) + 60'(digit);

  // Character step: advance the parse phase and the accumulators.
  always_comb begin
    upd_phase  = phase_q;
    upd_neg    = neg_q;
    upd_whole  = whole_q;
    upd_frac   = frac_q;
    upd_digits = digits_q;
    if (!no_char_i) begin
      case (phase_q)
        PhStart: begin
          if (text_char_i == CharMinus) begin
            upd_neg   = 1'b1;
            upd_phase = PhWhole;
          end else if (text_char_i == CharPlus) begin
            upd_phase = PhWhole;
          end else if (is_digit) begin
            upd_whole = VALUE_BITS'(digit);
            upd_phase = PhWhole;
          end else if (text_char_i == CharDot) begin
            upd_phase = PhFrac;
          end else begin
            upd_phase = PhStop;
          end
        end
        PhWhole: begin
          if (is_digit) begin
            upd_whole = whole_x10;
          end else if (text_char_i == CharDot) begin
            upd_phase = PhFrac;
          end else begin
            upd_phase = PhStop;
          end
        end
        PhFrac: begin
          if (is_digit && (digits_q < scale_eff)) begin
            upd_frac   = frac_x10;
            upd_digits = digits_q + 5'd1;
          end else begin
            upd_phase = PhStop;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // The beat that ends a field returns the state to field start.
  always_comb begin
    if (field_end_i) begin
      phase_d  = PhStart;
      neg_d    = 1'b0;
      whole_d  = '0;
      frac_d   = '0;
      digits_d = '0;
    end else begin
      phase_d  = upd_phase;
      neg_d    = upd_neg;
      whole_d  = upd_whole;
      frac_d   = upd_frac;
      digits_d = upd_digits;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhStart;
      neg_q    <= 1'b0;
      whole_q  <= '0;
      frac_q   <= '0;
      digits_q <= '0;
    end else if (accept) begin
      phase_q  <= phase_d;
      neg_q    <= neg_d;
      whole_q  <= whole_d;
      frac_q   <= frac_d;
      digits_q <= digits_d;
    end
  end

  // Zero padding of the fraction up to the scale.
  logic [4:0] pad;
  assign pad = (upd_digits < scale_eff) ? (scale_eff - upd_digits) : 5'd0;

  // Operand register, loaded by the beat that ends a field.
  dtfp_operands_t op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_v_q <= 1'b0;
    end else if (accept && field_end_i) begin
      op_v_q <= 1'b1;
    end else if (res_ready) begin
      op_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && field_end_i) begin
      op_q.whole     <= 64'(upd_whole);
      op_q.frac      <= upd_frac;
      op_q.pow_scale <= pow_ten(scale_eff);
      op_q.pow_pad   <= pow_ten(pad);
      op_q.neg       <= upd_neg;
    end
  end

  // Scaling, sign and wrap.
  dtfp_result #(
    .VALUE_BITS(VALUE_BITS)
  ) u_result (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_valid_i    (op_v_q),
    .op_i          (op_q),
    .op_ready_o    (res_ready),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .scaled_value_o(scaled_value_o)
  );

endmodule
